// File: rtl/core/vdu_pkg.sv
// shared types and constants for the vector distance unit
package vdu_pkg;

  localparam int ELEM_W   = 16;
  localparam int LEN_W    = 13;
  localparam int DIST_W   = 44;
  localparam int DSQ_W    = 45;
  localparam int DOT_W    = 44;
  localparam int NORM_W   = 43;
  localparam int ROOT_W   = 23;
  localparam int SQ_IN_W  = 2 * ROOT_W;
  localparam int SQ_REM_W = ROOT_W + 3;
  localparam int SQ_CNT_W = 5;
  localparam int DIV_N_W  = DOT_W + 16;
  localparam int DIV_D_W  = 44;
  localparam int DIV_CNT_W = 6;

  localparam logic [1:0] METRIC_L2  = 2'd0;
  localparam logic [1:0] METRIC_COS = 2'd1;
  localparam logic [1:0] METRIC_NIP = 2'd2;

  localparam logic [1:0] SQ_SEL_DSQ = 2'd0;
  localparam logic [1:0] SQ_SEL_NA  = 2'd1;
  localparam logic [1:0] SQ_SEL_NB  = 2'd2;

  localparam logic [16:0] ONE_Q16 = 17'd65536;

  typedef struct packed {
    logic signed [ELEM_W-1:0] elem_a;
    logic signed [ELEM_W-1:0] elem_b;
    logic [LEN_W-1:0]         length_a;
    logic [LEN_W-1:0]         length_b;
    logic                     last;
  } vdu_in_t;

  typedef struct packed {
    logic signed [DIST_W-1:0] distance;
    logic                     length_mismatch;
  } vdu_out_t;

  typedef struct packed {
    logic       acc;
    logic       sq_start;
    logic [1:0] sq_sel;
    logic       save_ra;
    logic       mul;
    logic       div_start;
    logic       load_out;
  } vdu_cmd_t;

  typedef struct packed {
    logic       last;
    logic       mismatch;
    logic [1:0] metric;
    logic       sq_busy;
    logic       div_busy;
    logic       out_busy;
  } vdu_stat_t;

endpackage

// File: rtl/core/vdu_ctrl.sv
// controller: sequences accumulation, roots, division and result load
module vdu_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              out_ready,
  input  vdu_pkg::vdu_stat_t stat,
  output vdu_pkg::vdu_cmd_t  cmd
);
  import vdu_pkg::*;

  localparam logic [2:0] ST_ACC    = 3'd0;
  localparam logic [2:0] ST_DECIDE = 3'd1;
  localparam logic [2:0] ST_SQ_A   = 3'd2;
  localparam logic [2:0] ST_SQ_B   = 3'd3;
  localparam logic [2:0] ST_DIVST  = 3'd4;
  localparam logic [2:0] ST_DIV    = 3'd5;
  localparam logic [2:0] ST_FIN    = 3'd6;

  logic [2:0] state_r, state_nxt;

  assign in_ready = (state_r == ST_ACC);

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    unique case (state_r)
      ST_ACC: begin
        if (in_valid) begin
          cmd.acc = 1'b1;
          if (stat.last) state_nxt = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        if (stat.mismatch) begin
          state_nxt = ST_FIN;
        end else if (stat.metric == METRIC_L2) begin
          cmd.sq_start = 1'b1;
          cmd.sq_sel = SQ_SEL_DSQ;
          state_nxt = ST_SQ_A;
        end else if (stat.metric == METRIC_COS) begin
          cmd.sq_start = 1'b1;
          cmd.sq_sel = SQ_SEL_NA;
          state_nxt = ST_SQ_A;
        end else begin
          state_nxt = ST_FIN;
        end
      end
      ST_SQ_A: begin
        if (!stat.sq_busy) begin
          if (stat.metric == METRIC_COS) begin
            cmd.save_ra = 1'b1;
            cmd.sq_start = 1'b1;
            cmd.sq_sel = SQ_SEL_NB;
            state_nxt = ST_SQ_B;
          end else begin
            state_nxt = ST_FIN;
          end
        end
      end
      ST_SQ_B: begin
        if (!stat.sq_busy) begin
          cmd.mul = 1'b1;
          state_nxt = ST_DIVST;
        end
      end
      ST_DIVST: begin
        cmd.div_start = 1'b1;
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        if (!stat.div_busy) state_nxt = ST_FIN;
      end
      ST_FIN: begin
        if (!stat.out_busy || out_ready) begin
          cmd.load_out = 1'b1;
          state_nxt = ST_ACC;
        end
      end
      default: state_nxt = ST_ACC;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_ACC;
    else state_r <= state_nxt;
  end

  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.sq_start |-> !stat.sq_busy) else $error("root started while busy");
  a_div_after_roots: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_start |-> $past(cmd.mul)) else $error("divide without denominator");
  a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.acc, cmd.mul, cmd.div_start, cmd.load_out}))
    else $error("conflicting commands");

endmodule

// File: rtl/core/vdu_datapath.sv
// datapath: accumulators, shared root unit, divider and result register
module vdu_datapath (
  input  logic              clk,
  input  logic              rst_n,
  input  vdu_pkg::vdu_in_t  in_data,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_wdata,
  input  vdu_pkg::vdu_cmd_t cmd,
  output vdu_pkg::vdu_stat_t stat,
  input  logic              out_ready,
  output logic              out_valid,
  output vdu_pkg::vdu_out_t out_data
);
  import vdu_pkg::*;

  localparam logic [DSQ_W-1:0]  DSQ_MAX  = {DSQ_W{1'b1}};
  localparam logic [NORM_W-1:0] NORM_MAX = {NORM_W{1'b1}};
  localparam logic signed [DOT_W-1:0] DOT_MAX = {1'b0, {(DOT_W-1){1'b1}}};
  localparam logic signed [DOT_W-1:0] DOT_MIN = {1'b1, {(DOT_W-1){1'b0}}};

  logic [1:0] metric_r;
  logic [DSQ_W-1:0] dsq_r;
  logic signed [DOT_W-1:0] dot_r;
  logic [NORM_W-1:0] na_r, nb_r;
  logic mismatch_r, first_pending_r;

  // accumulate one pair
  logic signed [ELEM_W:0] diff;
  logic [ELEM_W:0] diff_mag;
  logic [2*ELEM_W:0] sq_d;
  logic [2*ELEM_W-1:0] sq_a, sq_b;
  logic signed [2*ELEM_W-1:0] prod;
  logic [DSQ_W:0] dsq_sum;
  logic [NORM_W:0] na_sum, nb_sum;
  logic signed [DOT_W:0] dot_sum;
  logic mismatch_nxt;

  always_comb begin
    diff = ELEM_W'(0) + {in_data.elem_a[ELEM_W-1], in_data.elem_a}
           - {in_data.elem_b[ELEM_W-1], in_data.elem_b};
    diff_mag = diff[ELEM_W] ? (ELEM_W+1)'(-diff) : diff;
    sq_d = (2*ELEM_W+1)'(diff_mag * diff_mag);
    sq_a = 2*ELEM_W'(0) + (2*ELEM_W)'($signed(in_data.elem_a) * $signed(in_data.elem_a));
    sq_b = (2*ELEM_W)'($signed(in_data.elem_b) * $signed(in_data.elem_b));
    prod = $signed(in_data.elem_a) * $signed(in_data.elem_b);
    dsq_sum = {1'b0, dsq_r} + (DSQ_W+1)'(sq_d);
    na_sum = {1'b0, na_r} + (NORM_W+1)'(sq_a);
    nb_sum = {1'b0, nb_r} + (NORM_W+1)'(sq_b);
    dot_sum = {dot_r[DOT_W-1], dot_r} + (DOT_W+1)'(prod);
    mismatch_nxt = first_pending_r ? (in_data.length_a != in_data.length_b) : mismatch_r;
  end

  // root unit, two bits a step
  logic [SQ_IN_W-1:0] sq_n_r;
  logic [SQ_REM_W-1:0] sq_rem_r;
  logic [ROOT_W-1:0] sq_root_r, ra_r;
  logic [SQ_CNT_W-1:0] sq_cnt_r;
  logic sq_busy_r;
  logic [SQ_REM_W+1:0] sq_sh, sq_trial;
  logic [SQ_IN_W-1:0] sq_op;

  always_comb begin
    sq_sh = {sq_rem_r, sq_n_r[SQ_IN_W-1 -: 2]};
    sq_trial = (SQ_REM_W+2)'({sq_root_r, 2'b01});
    case (cmd.sq_sel)
      SQ_SEL_NA: sq_op = SQ_IN_W'(na_r);
      SQ_SEL_NB: sq_op = SQ_IN_W'(nb_r);
      default:   sq_op = SQ_IN_W'(dsq_r);
    endcase
  end

  // restoring divider, one quotient bit a step
  logic [DIV_D_W-1:0] den_r;
  logic [DIV_N_W-1:0] div_q_r;
  logic [DIV_D_W-1:0] div_rem_r;
  logic [DIV_CNT_W-1:0] div_cnt_r;
  logic div_busy_r;
  logic [DIV_D_W:0] div_sh;
  logic div_ge;
  logic [DOT_W-1:0] dot_mag;

  always_comb begin
    div_sh = {div_rem_r, div_q_r[DIV_N_W-1]};
    div_ge = div_sh >= {1'b0, den_r};
    dot_mag = dot_r[DOT_W-1] ? DOT_W'(-dot_r) : DOT_W'(dot_r);
  end

  // result select
  logic [16:0] cos_mag;
  logic signed [DIST_W-1:0] dist_val;

  always_comb begin
    cos_mag = (div_q_r > DIV_N_W'(ONE_Q16)) ? ONE_Q16 : div_q_r[16:0];
    case (metric_r)
      METRIC_L2: begin
        dist_val = mismatch_r ? -DIST_W'(256) : DIST_W'(sq_root_r);
      end
      METRIC_COS: begin
        if (mismatch_r) dist_val = -DIST_W'(65536);
        else if (ra_r == '0 || sq_root_r == '0) dist_val = '0;
        else if (dot_r[DOT_W-1]) dist_val = -DIST_W'(cos_mag);
        else dist_val = DIST_W'(cos_mag);
      end
      METRIC_NIP: begin
        if (mismatch_r) dist_val = '0;
        else if (dot_r == DOT_MIN) dist_val = DOT_MAX;
        else dist_val = -dot_r;
      end
      default: dist_val = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      metric_r <= METRIC_L2;
      dsq_r <= '0;
      dot_r <= '0;
      na_r <= '0;
      nb_r <= '0;
      mismatch_r <= 1'b0;
      first_pending_r <= 1'b1;
      sq_busy_r <= 1'b0;
      div_busy_r <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) metric_r <= cfg_wdata;
      if (cmd.acc) begin
        mismatch_r <= mismatch_nxt;
        first_pending_r <= 1'b0;
        dsq_r <= dsq_sum[DSQ_W] ? DSQ_MAX : dsq_sum[DSQ_W-1:0];
        na_r <= na_sum[NORM_W] ? NORM_MAX : na_sum[NORM_W-1:0];
        nb_r <= nb_sum[NORM_W] ? NORM_MAX : nb_sum[NORM_W-1:0];
        if (dot_sum > (DOT_W+1)'(DOT_MAX)) dot_r <= DOT_MAX;
        else if (dot_sum < (DOT_W+1)'(DOT_MIN)) dot_r <= DOT_MIN;
        else dot_r <= dot_sum[DOT_W-1:0];
      end
      if (cmd.sq_start) begin
        sq_busy_r <= 1'b1;
      end else if (sq_busy_r && sq_cnt_r == SQ_CNT_W'(ROOT_W - 1)) begin
        sq_busy_r <= 1'b0;
      end
      if (cmd.div_start) begin
        div_busy_r <= 1'b1;
      end else if (div_busy_r && div_cnt_r == DIV_CNT_W'(DIV_N_W - 1)) begin
        div_busy_r <= 1'b0;
      end
      if (cmd.load_out) begin
        out_valid <= 1'b1;
        dsq_r <= '0;
        dot_r <= '0;
        na_r <= '0;
        nb_r <= '0;
        mismatch_r <= 1'b0;
        first_pending_r <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.save_ra) ra_r <= sq_root_r;
    if (cmd.sq_start) begin
      sq_n_r <= sq_op;
      sq_rem_r <= '0;
      sq_root_r <= '0;
      sq_cnt_r <= '0;
    end else if (sq_busy_r) begin
      sq_n_r <= {sq_n_r[SQ_IN_W-3:0], 2'b00};
      sq_cnt_r <= sq_cnt_r + 1'b1;
      if (sq_sh >= sq_trial) begin
        sq_rem_r <= SQ_REM_W'(sq_sh - sq_trial);
        sq_root_r <= {sq_root_r[ROOT_W-2:0], 1'b1};
      end else begin
        sq_rem_r <= SQ_REM_W'(sq_sh);
        sq_root_r <= {sq_root_r[ROOT_W-2:0], 1'b0};
      end
    end
    if (cmd.mul) den_r <= DIV_D_W'(ra_r * sq_root_r);
    if (cmd.div_start) begin
      div_q_r <= {dot_mag, 16'd0};
      div_rem_r <= '0;
      div_cnt_r <= '0;
    end else if (div_busy_r) begin
      div_cnt_r <= div_cnt_r + 1'b1;
      div_q_r <= {div_q_r[DIV_N_W-2:0], div_ge};
      div_rem_r <= div_ge ? DIV_D_W'(div_sh - {1'b0, den_r}) : DIV_D_W'(div_sh);
    end
    if (cmd.load_out) begin
      out_data.distance <= dist_val;
      out_data.length_mismatch <= mismatch_r;
    end
  end

  assign stat.last = in_data.last;
  assign stat.mismatch = mismatch_r;
  assign stat.metric = metric_r;
  assign stat.sq_busy = sq_busy_r;
  assign stat.div_busy = div_busy_r;
  assign stat.out_busy = out_valid;

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> (!out_valid || out_ready)) else $error("result overwritten");
  a_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |=> (first_pending_r && dsq_r == '0 && dot_r == '0))
    else $error("accumulators not cleared");
  a_cos_range: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.load_out && metric_r == METRIC_COS) |=>
      (out_data.distance <= DIST_W'(65536) && out_data.distance >= -DIST_W'(65536)))
    else $error("cosine out of range");

endmodule

// File: rtl/core/vector_distance_unit.sv
// Vector distance unit top level. Element pairs are accepted one per cycle while
// accumulating; the pair marked last closes the couple, and the block then stops
// taking pairs while it forms the result: the inner product or any length mismatch
// goes straight to the result load, L2 takes one 23-step root, and cosine takes
// two 23-step roots on the shared root unit, one multiply and a 60-step restoring
// divide. A finished result sits in the output register, so the next couple may
// start streaming before that result is taken.
module vector_distance_unit (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  vdu_pkg::vdu_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output vdu_pkg::vdu_out_t out_data,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_wdata
);
  import vdu_pkg::*;

  vdu_cmd_t  cmd;
  vdu_stat_t stat;

  vdu_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .out_ready(out_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  vdu_datapath u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .cmd      (cmd),
    .stat     (stat),
    .out_ready(out_ready),
    .out_valid(out_valid),
    .out_data (out_data)
  );

endmodule
